// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the countdown clock.
// Plain text macros only; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, ignored while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/tscc_pkg.sv =====
// Package for the two-side countdown clock: field widths, command and
// register codes, reset values and display rounding constants. No dependencies.
`default_nettype none

package tscc_pkg;

   localparam int unsigned MS_W      = 32;
   localparam int unsigned SHOWN_W   = 23;
   localparam int unsigned CSR_IDX_W = 2;

   typedef enum logic [2:0] {
      CMD_NEW_GAME = 3'd0,
      CMD_START    = 3'd1,
      CMD_STOP     = 3'd2,
      CMD_MOVE     = 3'd3,
      CMD_SWITCH   = 3'd4,
      CMD_QUERY    = 3'd5
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE_TIME = 2'd0,
      CSR_INCREMENT = 2'd1
   } csr_idx_type;

   localparam logic [MS_W-1:0] RESET_BASE_MS = 32'd300000;
   localparam logic [MS_W-1:0] FAST_BELOW_MS = 32'd10000;
   localparam logic [MS_W-1:0] FAST_STEP_MS  = 32'd100;
   localparam logic [MS_W-1:0] SLOW_STEP_MS  = 32'd1000;

   // Both steps divide 1000, so floor(ceil(ms/step)*step/1000) equals
   // floor((ms + step - 1)/1000).
   localparam logic [MS_W:0] FAST_ROUND = {1'b0, FAST_STEP_MS - 32'd1};
   localparam logic [MS_W:0] SLOW_ROUND = {1'b0, SLOW_STEP_MS - 32'd1};

   // floor(a/1000) = floor((a >> 3) * DIV_MULT >> DIV_SHIFT), exact for a < 2^33.
   localparam int unsigned    DIV_PRE   = 3;
   localparam int unsigned    DIV_N_W   = MS_W + 1 - DIV_PRE;
   localparam int unsigned    DIV_M_W   = 31;
   localparam int unsigned    DIV_SHIFT = 37;
   localparam logic [DIV_M_W-1:0] DIV_MULT = 31'd1099511628;

endpackage

`default_nettype wire

// ===== hw/rtl/two_side_countdown_clock.sv =====
// Top level of the two-side countdown clock with Fischer increment.
// Depends on tscc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// Two-side countdown clock. Each transfer on the req channel carries a command
// (new game, start, stop, move made, switch side, query; codes six and seven
// act as query), a side and a wrapping millisecond timestamp; each one gives
// exactly one transfer on the rsp channel with both remaining times at that
// timestamp, their display seconds (rounded up to 100 ms below ten seconds,
// to whole seconds above) and the running, active side and enabled flags.
// The block takes one transfer per cycle for as long as the rsp side keeps up;
// each request, once accepted, passes through an input register, the clock
// state update (a wrapping subtract, a floored compare and a saturating
// increment add), one constant-reciprocal multiply per side for the display
// seconds, and then the output register. Bubbles are squeezed
// out, so a stalled result holds only as much of the pipeline as is full.
// Configuration writes (base time, increment) are always taken; they are
// meant to be made while no request is in flight, and the base time takes
// effect at the next new game. A base time of zero disables the clock.
module two_side_countdown_clock
   import tscc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // request channel
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [31:0]          req_tdata,  // now_ms[31:0]
   input  wire logic [3:0]           req_tuser,  // cmd[2:0], side[3]
   // result channel
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   // white_left_ms[31:0], black_left_ms[63:32], white_shown_s[86:64],
   // black_shown_s[109:87], is_running[110], active_side[111],
   // clock_enabled[112], zero[119:113]
   output logic [119:0]              rsp_tdata,
   // configuration write channel
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [MS_W-1:0]      csr_data
);

   // Configuration registers
   logic [MS_W-1:0] base_ff;
   logic [MS_W-1:0] inc_ff;

   // Clock state
   logic [1:0][MS_W-1:0] tl_ff, tl_in;
   logic                 run_ff, run_in;
   logic                 side_ff, side_in;
   logic [MS_W-1:0]      stamp_ff, stamp_in;
   logic                 en_ff, en_in;

   // Stage 0: input register
   logic            v0_ff;
   logic [2:0]      s0_cmd_ff;
   logic            s0_side_ff;
   logic [MS_W-1:0] s0_now_ff;

   // Stage 1: remaining times and flags after the command
   logic            v1_ff;
   logic [MS_W-1:0] s1_w_ff, s1_b_ff;
   logic            s1_run_ff, s1_side_ff, s1_en_ff;

   // Stage 2: display seconds out of the multipliers
   logic               v2_ff;
   logic [MS_W-1:0]    s2_w_ff, s2_b_ff;
   logic [SHOWN_W-1:0] s2_ws_ff, s2_bs_ff;
   logic               s2_run_ff, s2_side_ff, s2_en_ff;

   // Stage 3: output register
   logic               v3_ff;
   logic [MS_W-1:0]    s3_w_ff, s3_b_ff;
   logic [SHOWN_W-1:0] s3_ws_ff, s3_bs_ff;
   logic               s3_run_ff, s3_side_ff, s3_en_ff;

   // Advance enables: a stage loads when it is empty or its content moves on
   logic adv3, take2, take1, take0;

   assign adv3       = !v3_ff || rsp_tready;
   assign take2      = !v2_ff || adv3;
   assign take1      = !v1_ff || take2;
   assign take0      = !v0_ff || take1;
   assign req_tready = take0;
   assign csr_ready  = 1'b1;

   // ---------------------------------------------------------------------
   // State update for the item in stage 0
   // ---------------------------------------------------------------------
   logic [MS_W-1:0] cur_left, spent, ded, charged, bumped;
   logic [MS_W:0]   sum;
   logic            live_q;
   logic [MS_W-1:0] w_in, b_in;

   always_comb begin
      cur_left = tl_ff[side_ff];
      spent    = s0_now_ff - stamp_ff;               // wraps modulo 2^32
      ded      = (spent >= cur_left) ? '0 : cur_left - spent;
      charged  = run_ff ? ded : cur_left;
      sum      = {1'b0, charged} + {1'b0, inc_ff};
      // add the increment only while time remains, saturating at all ones
      if (charged == '0) begin
         bumped = charged;
      end else if (sum[MS_W]) begin
         bumped = '1;
      end else begin
         bumped = sum[MS_W-1:0];
      end

      tl_in    = tl_ff;
      run_in   = run_ff;
      side_in  = side_ff;
      stamp_in = stamp_ff;
      en_in    = en_ff;
      live_q   = 1'b0;

      unique case (cmd_type'(s0_cmd_ff))
         CMD_NEW_GAME: begin
            tl_in    = {base_ff, base_ff};
            run_in   = 1'b0;
            side_in  = 1'b0;
            stamp_in = '0;
            en_in    = (base_ff != '0);
         end
         CMD_START: begin
            if (en_ff) begin
               side_in  = s0_side_ff;
               stamp_in = s0_now_ff;
               run_in   = 1'b1;
            end
         end
         CMD_STOP: begin
            if (run_ff) begin
               tl_in[side_ff] = ded;
               stamp_in       = s0_now_ff;
            end
            run_in = 1'b0;
         end
         CMD_MOVE: begin
            if (en_ff) begin
               tl_in[side_ff] = bumped;
               side_in        = !side_ff;
               stamp_in       = s0_now_ff;
               run_in         = 1'b1;
            end
         end
         CMD_SWITCH: begin
            if (en_ff) begin
               tl_in[side_ff] = charged;
               side_in        = s0_side_ff;
               stamp_in       = s0_now_ff;
               run_in         = 1'b1;
            end
         end
         default: begin
            // query: state holds, the charged side reads live
            live_q = run_ff;
         end
      endcase

      // every other command leaves the stamp at now or the clock stopped, so the stored value is live
      w_in = (live_q && !side_ff) ? ded : tl_in[0];
      b_in = (live_q &&  side_ff) ? ded : tl_in[1];
   end

   // ---------------------------------------------------------------------
   // Display seconds: floor((ms + step - 1) / 1000) by reciprocal multiply
   // ---------------------------------------------------------------------
   logic [MS_W:0]                 w_rnd, b_rnd;
   logic [DIV_N_W+DIV_M_W-1:0]    w_prod, b_prod;

   always_comb begin
      w_rnd  = {1'b0, s1_w_ff} + ((s1_w_ff < FAST_BELOW_MS) ? FAST_ROUND : SLOW_ROUND);
      b_rnd  = {1'b0, s1_b_ff} + ((s1_b_ff < FAST_BELOW_MS) ? FAST_ROUND : SLOW_ROUND);
      w_prod = {{DIV_M_W{1'b0}}, w_rnd[MS_W:DIV_PRE]} * {{DIV_N_W{1'b0}}, DIV_MULT};
      b_prod = {{DIV_M_W{1'b0}}, b_rnd[MS_W:DIV_PRE]} * {{DIV_N_W{1'b0}}, DIV_MULT};
   end

   // ---------------------------------------------------------------------
   // Control registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= RESET_BASE_MS;
         inc_ff   <= '0;
         tl_ff    <= {RESET_BASE_MS, RESET_BASE_MS};
         run_ff   <= 1'b0;
         side_ff  <= 1'b0;
         stamp_ff <= '0;
         en_ff    <= (RESET_BASE_MS != '0);
         v0_ff    <= 1'b0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
      end else begin
         if (csr_valid) begin
            if (csr_index == CSR_BASE_TIME) begin
               base_ff <= csr_data;
            end else if (csr_index == CSR_INCREMENT) begin
               inc_ff <= csr_data;
            end
         end
         // commit the clock state as the item leaves stage 0
         if (take1 && v0_ff) begin
            tl_ff    <= tl_in;
            run_ff   <= run_in;
            side_ff  <= side_in;
            stamp_ff <= stamp_in;
            en_ff    <= en_in;
         end
         if (take0) v0_ff <= req_tvalid;
         if (take1) v1_ff <= v0_ff;
         if (take2) v2_ff <= v1_ff;
         if (adv3)  v3_ff <= v2_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Payload registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (take0) begin
         s0_cmd_ff  <= req_tuser[2:0];
         s0_side_ff <= req_tuser[3];
         s0_now_ff  <= req_tdata;
      end
      if (take1) begin
         s1_w_ff    <= w_in;
         s1_b_ff    <= b_in;
         s1_run_ff  <= run_in;
         s1_side_ff <= side_in;
         s1_en_ff   <= en_in;
      end
      if (take2) begin
         s2_w_ff    <= s1_w_ff;
         s2_b_ff    <= s1_b_ff;
         s2_ws_ff   <= w_prod[DIV_SHIFT +: SHOWN_W];
         s2_bs_ff   <= b_prod[DIV_SHIFT +: SHOWN_W];
         s2_run_ff  <= s1_run_ff;
         s2_side_ff <= s1_side_ff;
         s2_en_ff   <= s1_en_ff;
      end
      if (adv3) begin
         s3_w_ff    <= s2_w_ff;
         s3_b_ff    <= s2_b_ff;
         s3_ws_ff   <= s2_ws_ff;
         s3_bs_ff   <= s2_bs_ff;
         s3_run_ff  <= s2_run_ff;
         s3_side_ff <= s2_side_ff;
         s3_en_ff   <= s2_en_ff;
      end
   end

   assign rsp_tvalid = v3_ff;
   assign rsp_tdata  = {7'd0, s3_en_ff, s3_side_ff, s3_run_ff,
                        s3_bs_ff, s3_ws_ff, s3_b_ff, s3_w_ff};

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // a disabled clock never runs
   `ASSERT_IMPLIES(a_disabled_idle, clock, reset, !en_ff, !run_ff)
   // an empty output register never holds back the request side
   `ASSERT_IMPLIES(a_ready_when_empty, clock, reset, !v3_ff, req_tready)
   // a move on an enabled clock hands the clock to the other side, running
   `ASSERT_NEXT(a_move_hands_over, clock, reset,
      take1 && v0_ff && en_ff && (s0_cmd_ff == CMD_MOVE),
      run_ff && (side_ff != $past(side_ff)))

endmodule

`default_nettype wire
